// ===== rtl/fuu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuu_pkg: shared types and constants of the float unary unit
// Operation codes, format constants and the classified item record that
// travels from the front end through the queue to the execution back end.
// ----------------------------------------------------------------------------
package fuu_pkg;

	localparam logic [2:0] CMD_ABS     = 3'd0;
	localparam logic [2:0] CMD_NEG     = 3'd1;
	localparam logic [2:0] CMD_SQRT    = 3'd2;
	localparam logic [2:0] CMD_CEIL    = 3'd3;
	localparam logic [2:0] CMD_FLOOR   = 3'd4;
	localparam logic [2:0] CMD_TRUNC   = 3'd5;
	localparam logic [2:0] CMD_NEAREST = 3'd6;

	localparam logic [63:0] SIGN_D  = 64'h8000_0000_0000_0000;
	localparam logic [63:0] SIGN_S  = 64'h0000_0000_8000_0000;
	localparam logic [63:0] QBIT_D  = 64'h0008_0000_0000_0000;
	localparam logic [63:0] QBIT_S  = 64'h0000_0000_0040_0000;
	localparam logic [63:0] CNAN_D  = 64'h7ff8_0000_0000_0000;
	localparam logic [63:0] CNAN_S  = 64'h0000_0000_7fc0_0000;
	localparam logic [63:0] ONE_D   = 64'h3ff0_0000_0000_0000;
	localparam logic [63:0] ONE_S   = 64'h0000_0000_3f80_0000;
	localparam logic [10:0] BIAS_D  = 11'd1023;
	localparam logic [10:0] BIAS_S  = 11'd127;
	localparam logic [10:0] EMAX_D  = 11'd2047;
	localparam logic [10:0] EMAX_S  = 11'd255;
	localparam logic [5:0]  MB_D    = 6'd52;
	localparam logic [5:0]  MB_S    = 6'd23;

	// Classified item: operand masked to its width plus decode results.
	typedef struct packed {
		logic [2:0]  cmd;
		logic        dbl;
		logic [63:0] x;
		logic [63:0] mag;
		logic [51:0] mant;
		logic [10:0] e;
		logic        neg;
		logic        is_nan;
		logic        exp_max;
		logic        zero;
		logic        big;
		logic        tiny;
		logic        tiny_half_up;
		logic [63:0] frac_mask;
	} fuu_item_t;

	typedef struct packed {
		logic        start;
		logic        ack;
	} fuu_sq_ctl_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] res;
	} fuu_sq_sts_t;

endpackage

// ===== rtl/fuu_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuu_in_if / fuu_out_if: valid-ready channels of the float unary unit
// Operand channel carries command, precision and bits; result channel bits.
// ----------------------------------------------------------------------------
interface fuu_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic        is_double;
	logic [63:0] operand_bits;
	modport source (output valid, command, is_double, operand_bits, input ready);
	modport sink (input valid, command, is_double, operand_bits, output ready);
endinterface

interface fuu_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_bits;
	modport source (output valid, result_bits, input ready);
	modport sink (input valid, result_bits, output ready);
endinterface

// ===== rtl/fuu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuu_front: operand decode
// Mask the operand to its precision and classify it for the back end.
// ----------------------------------------------------------------------------
module fuu_front (
	input  logic [2:0]        command,
	input  logic              is_double,
	input  logic [63:0]       operand_bits,
	output fuu_pkg::fuu_item_t item
);
	logic [63:0] x;
	logic [10:0] bias;
	logic [10:0] emax;
	logic [11:0] lim;
	logic [11:0] fb_w;
	logic [5:0]  fb;
	logic [63:0] one_below;

	always_comb begin
		x    = is_double ? operand_bits : {32'd0, operand_bits[31:0]};
		bias = is_double ? fuu_pkg::BIAS_D : fuu_pkg::BIAS_S;
		emax = is_double ? fuu_pkg::EMAX_D : fuu_pkg::EMAX_S;
		lim  = {1'b0, bias} + {6'd0, (is_double ? fuu_pkg::MB_D : fuu_pkg::MB_S)};

		item.cmd  = command;
		item.dbl  = is_double;
		item.x    = x;
		item.mag  = is_double ? {1'b0, x[62:0]} : {33'd0, x[30:0]};
		item.mant = is_double ? x[51:0] : {29'd0, x[22:0]};
		item.e    = is_double ? x[62:52] : {3'd0, x[30:23]};
		item.neg  = is_double ? x[63] : x[31];
		item.exp_max = (item.e == emax);
		item.is_nan  = item.exp_max && (item.mant != 52'd0);
		item.zero    = (item.mag == 64'd0);
		item.big     = ({1'b0, item.e} >= lim);
		item.tiny    = (item.e < bias);
		// magnitude of one half: (bias-1) in the exponent field
		one_below = is_double ? {1'b0, 11'd1022, 52'd0} : {33'd0, 8'd126, 23'd0};
		item.tiny_half_up = (item.e == bias - 11'd1) && (item.mag > one_below);
		fb_w = lim - {1'b0, item.e};
		fb   = fb_w[5:0];
		item.frac_mask = ~({64{1'b1}} << fb);
	end
endmodule

// ===== rtl/fuu_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuu_queue: four-entry item queue
// Decouple the decode front from the execution back end.
// ----------------------------------------------------------------------------
module fuu_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  fuu_pkg::fuu_item_t push_item,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output fuu_pkg::fuu_item_t head_item
);
	fuu_pkg::fuu_item_t mem_q [4];
	logic [1:0] wptr_q;
	logic [1:0] rptr_q;
	logic [2:0] cnt_q;

	assign full       = (cnt_q == 3'd4);
	assign head_valid = (cnt_q != 3'd0);
	assign head_item  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 2'd0;
			rptr_q <= 2'd0;
			cnt_q  <= 3'd0;
		end else begin
			if (push) wptr_q <= wptr_q + 2'd1;
			if (pop) rptr_q <= rptr_q + 2'd1;
			if (push && !pop) cnt_q <= cnt_q + 3'd1;
			else if (pop && !push) cnt_q <= cnt_q - 3'd1;
		end
	end
endmodule

// ===== rtl/fuu_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuu_sqrt: bit-serial square root of a finite positive operand
// Normalize one bit per cycle, then one result bit per cycle, then round.
// ----------------------------------------------------------------------------
module fuu_sqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  fuu_pkg::fuu_sq_ctl_t ctl,
	input  logic               dbl,
	input  logic [10:0]        e,
	input  logic [51:0]        mant,
	output fuu_pkg::fuu_sq_sts_t sts
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_NORM = 2'd1;
	localparam logic [1:0] ST_ITER = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]         state_q;
	logic               dbl_q;
	logic [63:0]        ix_q;
	logic [63:0]        s_q;
	logic [63:0]        r_q;
	logic [63:0]        q_q;
	logic signed [12:0] ex_q;

	logic               hidden;
	logic [63:0]        t;
	logic [63:0]        ix_odd;
	logic signed [12:0] ex_even;
	logic [63:0]        qf;
	logic [12:0]        efield;
	logic [63:0]        eshift;
	logic [10:0]        bias;

	always_comb begin
		bias    = dbl_q ? fuu_pkg::BIAS_D : fuu_pkg::BIAS_S;
		hidden  = dbl_q ? ix_q[52] : ix_q[23];
		ix_odd  = ex_q[0] ? (ix_q << 1) : ix_q;
		ex_even = ex_q[0] ? (ex_q - 13'sd1) : ex_q;
		t       = s_q + r_q;
		qf      = (q_q + {63'd0, q_q[0]}) >> 1;
		efield  = 13'(ex_q + $signed({2'b00, bias}) - 13'sd1);
		eshift  = dbl_q ? ({51'd0, efield} << 52) : ({51'd0, efield} << 23);
		sts.busy = (state_q != ST_IDLE);
		sts.done = (state_q == ST_DONE);
		sts.res  = eshift + qf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (ctl.start) state_q <= ST_NORM;
				ST_NORM: if (hidden) state_q <= ST_ITER;
				ST_ITER: if (r_q[0]) state_q <= ST_DONE;
				ST_DONE: if (ctl.ack) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				dbl_q <= dbl;
				if (e == 11'd0) begin
					ix_q <= {12'd0, mant};
					ex_q <= 13'sd1 - $signed({2'b00, (dbl ? fuu_pkg::BIAS_D : fuu_pkg::BIAS_S)});
				end else begin
					ix_q <= dbl ? {11'd1, mant} : {40'd1, mant[22:0]};
					ex_q <= $signed({2'b00, e}) -
						$signed({2'b00, (dbl ? fuu_pkg::BIAS_D : fuu_pkg::BIAS_S)});
				end
			end
			ST_NORM: begin
				if (!hidden) begin
					ix_q <= ix_q << 1;
					ex_q <= ex_q - 13'sd1;
				end else begin
					ix_q <= ix_odd << 1;
					ex_q <= ex_even >>> 1;
					s_q  <= 64'd0;
					q_q  <= 64'd0;
					r_q  <= dbl_q ? (64'd1 << 53) : (64'd1 << 24);
				end
			end
			ST_ITER: begin
				if (t <= ix_q) begin
					s_q  <= t + r_q;
					ix_q <= (ix_q - t) << 1;
					q_q  <= q_q + r_q;
				end else begin
					ix_q <= ix_q << 1;
				end
				r_q <= r_q >> 1;
			end
			default: begin
			end
		endcase
	end
endmodule

// ===== rtl/fuu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuu_back: execution back end
// Resolve sign, rounding and special cases combinationally; hand square
// roots of finite positive operands to the serial unit; register the result.
// ----------------------------------------------------------------------------
module fuu_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  fuu_pkg::fuu_item_t head_item,
	output logic               pop,
	fuu_out_if.source          result
);
	fuu_pkg::fuu_sq_ctl_t sq_ctl;
	fuu_pkg::fuu_sq_sts_t sq_sts;

	logic        valid_q;
	logic [63:0] res_q;
	logic        load_ok;
	logic        needs_iter;
	logic [63:0] fast_res;
	logic [63:0] signbit;
	logic [63:0] qbit;
	logic [63:0] negbit;
	logic [63:0] frac;
	logic [63:0] tr;
	logic [63:0] unit;
	logic [63:0] half;
	logic        up;
	logic        load;
	logic [63:0] load_res;

	fuu_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sq_ctl),
		.dbl    (head_item.dbl),
		.e      (head_item.e),
		.mant   (head_item.mant),
		.sts    (sq_sts)
	);

	always_comb begin
		signbit = head_item.dbl ? fuu_pkg::SIGN_D : fuu_pkg::SIGN_S;
		qbit    = head_item.dbl ? fuu_pkg::QBIT_D : fuu_pkg::QBIT_S;
		negbit  = head_item.x & signbit;
		frac    = head_item.mag & head_item.frac_mask;
		tr      = head_item.mag & ~head_item.frac_mask;
		unit    = head_item.frac_mask + 64'd1;
		half    = unit >> 1;
		needs_iter = 1'b0;
		up = 1'b0;
		fast_res = head_item.x;

		case (head_item.cmd)
			fuu_pkg::CMD_CEIL:    up = !head_item.neg;
			fuu_pkg::CMD_FLOOR:   up = head_item.neg;
			fuu_pkg::CMD_NEAREST: up = head_item.tiny ? head_item.tiny_half_up :
				((frac > half) || ((frac == half) && ((tr & unit) != 64'd0)));
			default:              up = 1'b0;
		endcase

		case (head_item.cmd)
			fuu_pkg::CMD_ABS: fast_res = head_item.x & ~signbit;
			fuu_pkg::CMD_NEG: fast_res = head_item.x ^ signbit;
			fuu_pkg::CMD_SQRT: begin
				if (head_item.is_nan) fast_res = head_item.x | qbit;
				else if (head_item.zero) fast_res = head_item.x;
				else if (head_item.neg)
					fast_res = head_item.dbl ? fuu_pkg::CNAN_D : fuu_pkg::CNAN_S;
				else if (head_item.exp_max) fast_res = head_item.x;
				else needs_iter = 1'b1;
			end
			fuu_pkg::CMD_CEIL, fuu_pkg::CMD_FLOOR, fuu_pkg::CMD_TRUNC,
			fuu_pkg::CMD_NEAREST: begin
				if (head_item.is_nan) fast_res = head_item.x | qbit;
				else if (head_item.exp_max || head_item.zero || head_item.big)
					fast_res = head_item.x;
				else if (head_item.tiny)
					fast_res = negbit |
						(up ? (head_item.dbl ? fuu_pkg::ONE_D : fuu_pkg::ONE_S) : 64'd0);
				else if (frac == 64'd0) fast_res = head_item.x;
				else fast_res = negbit | (up ? tr + unit : tr);
			end
			default: fast_res = head_item.x;
		endcase
	end

	// Sqrt results leave ahead of anything queued behind them: hold the queue
	// while the serial unit is busy.
	always_comb begin
		load_ok      = !valid_q || result.ready;
		sq_ctl.start = 1'b0;
		sq_ctl.ack   = 1'b0;
		pop          = 1'b0;
		load         = 1'b0;
		load_res     = fast_res;
		if (sq_sts.done) begin
			if (load_ok) begin
				sq_ctl.ack = 1'b1;
				load       = 1'b1;
				load_res   = sq_sts.res;
			end
		end else if (!sq_sts.busy && head_valid) begin
			if (needs_iter) begin
				sq_ctl.start = 1'b1;
				pop          = 1'b1;
			end else if (load_ok) begin
				pop  = 1'b1;
				load = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_q <= load_res;
	end

	assign result.valid       = valid_q;
	assign result.result_bits = res_q;
endmodule

// ===== rtl/float_unary_unit_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_unary_unit_top: IEEE-754 abs, neg, sqrt, ceil, floor, trunc, nearest
// Single or double precision operand in, one result bit pattern out.
// ----------------------------------------------------------------------------
// Path: abs, neg, rounding and special-case sqrt results go from the operand
//   transfer through the queue to the result register. A finite positive sqrt
//   runs in the serial root unit: normalize steps (one for a normal operand,
//   one more per shift for a denormal), mb + 2 root bits, done, result load.
// Throughput: one item per cycle for non-sqrt work while results are taken;
//   the root unit holds the queue while it runs, so sqrt items pass one at
//   a time.
// Reset: arst_n clears the queue, the root unit and the result valid flag.
// ----------------------------------------------------------------------------
module float_unary_unit_top (
	input  logic       clk,
	input  logic       arst_n,
	fuu_in_if.sink     operand,
	fuu_out_if.source  result
);
	fuu_pkg::fuu_item_t dec_item;
	fuu_pkg::fuu_item_t head_item;
	logic               q_full;
	logic               head_valid;
	logic               pop;
	logic               push;

	// Decode straight off the port; the transfer writes the queue.
	fuu_front u_front (
		.command      (operand.command),
		.is_double    (operand.is_double),
		.operand_bits (operand.operand_bits),
		.item         (dec_item)
	);

	assign operand.ready = !q_full;
	assign push          = operand.valid && !q_full;

	// Short queue lets the front keep taking transfers while a root runs.
	fuu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (dec_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	// Execute in order and drive the registered result channel.
	fuu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.result     (result)
	);
endmodule
